[hw/rtl/wpf_pkg.sv]
package wpf_pkg;

    localparam int MAX_POINTS = 256;
    localparam int IDX_W      = $clog2(MAX_POINTS);
    localparam int LEN_W      = $clog2(MAX_POINTS + 1);

    localparam int CMD_W      = 2;
    localparam int COORD_W    = 20;
    localparam int DIFF_W     = COORD_W + 1;
    localparam int HEAD_W     = 15;
    localparam int ROBOT_W    = 18;
    localparam int ERR_W      = 19;
    localparam int SPEED_W    = 13;
    localparam int DIST_W     = 13;
    localparam int ANGLE_W    = 14;
    localparam int OUT_W      = 14;
    localparam int CFG_W      = 14;
    localparam int CFG_IDX_W  = 3;
    localparam int SQ_W       = 2 * DIST_W;
    localparam int D2_W       = 2 * DIFF_W;
    localparam int SQRT_W     = D2_W / 2;
    localparam int DIVS_W     = SQRT_W + 2;
    localparam int REM_W      = SQRT_W + 4;
    localparam int CNT_W      = $clog2(D2_W);

    localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_START = 2'd1;
    localparam logic [CMD_W-1:0] CMD_TICK  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_LOOKAHEAD = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HALT_DIST = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FIN_DIST  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_SPEED = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DEAD_ZONE = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_TURN  = 3'd5;

    localparam logic [DIST_W-1:0]  RST_LOOKAHEAD = 13'd82;
    localparam logic [DIST_W-1:0]  RST_HALT_DIST = 13'd51;
    localparam logic [DIST_W-1:0]  RST_FIN_DIST  = 13'd51;
    localparam logic [SPEED_W-1:0] RST_MIN_SPEED = 13'd384;
    localparam logic [ANGLE_W-1:0] RST_DEAD_ZONE = 14'd357;
    localparam logic [DIST_W-1:0]  RST_MAX_TURN  = 13'd6434;

    localparam logic signed [ERR_W-1:0] PI_Q12     = 19'sd12868;
    localparam logic signed [ERR_W-1:0] TWO_PI_Q12 = 19'sd25736;
    localparam logic [ANGLE_W-1:0]      MIN_ERR    = 14'd643;

    typedef enum logic
    {
        OP_SQRT,
        OP_DIV
    } arith_op_t;

    typedef struct packed
    {
        logic      go;
        arith_op_t op;
    } arith_req_t;

    typedef struct packed
    {
        logic                      halt;
        logic [SPEED_W-1:0]        speed;
        logic signed [HEAD_W-1:0]  heading;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] x;
    } way_t;

    localparam int WAY_W = $bits(way_t);

endpackage

[hw/rtl/wpf_ram.sv]
module wpf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

[hw/rtl/wpf_arith.sv]
module wpf_arith (
    input  logic                       clk,
    input  logic                       rst_n,
    input  wpf_pkg::arith_req_t        req,
    input  logic [wpf_pkg::D2_W-1:0]   arg,
    input  logic [wpf_pkg::DIVS_W-1:0] divisor,
    output logic                       busy,
    output logic                       done,
    output logic [wpf_pkg::D2_W-1:0]   result
);

    import wpf_pkg::*;

    localparam logic [CNT_W-1:0] SQRT_LAST = CNT_W'(SQRT_W - 1);
    localparam logic [CNT_W-1:0] DIV_LAST  = CNT_W'(D2_W - 1);

    logic              busy_reg;
    logic              done_reg;
    arith_op_t         op_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [D2_W-1:0]   x_reg;
    logic [D2_W-1:0]   q_reg;
    logic [REM_W-1:0]  rem_reg;
    logic [DIVS_W-1:0] dvs_reg;

    logic [REM_W-1:0] rem_sh;
    logic [REM_W-1:0] trial;
    logic             fit;
    logic [D2_W-1:0]  x_shift;
    logic             last;

    // sqrt brings two radicand bits per step, divide one
    always_comb
    begin
        if (op_reg == OP_SQRT)
        begin
            rem_sh  = {rem_reg[REM_W-3:0], x_reg[D2_W-1 -: 2]};
            trial   = REM_W'({q_reg[SQRT_W-1:0], 2'b01});
            x_shift = {x_reg[D2_W-3:0], 2'b00};
            last    = (cnt_reg == SQRT_LAST);
        end
        else
        begin
            rem_sh  = {rem_reg[REM_W-2:0], x_reg[D2_W-1]};
            trial   = REM_W'(dvs_reg);
            x_shift = {x_reg[D2_W-2:0], 1'b0};
            last    = (cnt_reg == DIV_LAST);
        end
        fit = (rem_sh >= trial);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            op_reg   <= OP_SQRT;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.go)
            begin
                busy_reg <= 1'b1;
                op_reg   <= req.op;
                cnt_reg  <= '0;
                x_reg    <= arg;
                q_reg    <= '0;
                rem_reg  <= '0;
                dvs_reg  <= divisor;
            end
            else if (busy_reg)
            begin
                x_reg   <= x_shift;
                q_reg   <= {q_reg[D2_W-2:0], fit};
                rem_reg <= fit ? (rem_sh - trial) : rem_sh;
                cnt_reg <= cnt_reg + 1'b1;
                if (last)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign busy   = busy_reg;
    assign done   = done_reg;
    assign result = q_reg;

endmodule

[hw/rtl/waypoint_path_follower.sv]
// Load and start transfers leave the controller idle; busy stays low.
// Control tick time grows with each waypoint scanned (up to 256) and is
// set by the shared sqrt/divide unit (21 and 42 steps) and the scan loop.
// One item at a time; the next start is taken once busy falls.
// Reset loads the config defaults and clears path length, index and halt latch;
// the waypoint store holds no reset value. Results cannot be stalled.
module waypoint_path_follower (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic [wpf_pkg::CMD_W-1:0]          command,
    input  logic signed [wpf_pkg::COORD_W-1:0] point_x,
    input  logic signed [wpf_pkg::COORD_W-1:0] point_y,
    input  logic signed [wpf_pkg::HEAD_W-1:0]  point_heading,
    input  logic [wpf_pkg::SPEED_W-1:0]        point_speed,
    input  logic                               point_halt,
    input  logic                               point_last,
    input  logic signed [wpf_pkg::COORD_W-1:0] pose_x,
    input  logic signed [wpf_pkg::COORD_W-1:0] pose_y,
    input  logic signed [wpf_pkg::ROBOT_W-1:0] robot_heading,
    input  logic                               cfg_write,
    input  logic [wpf_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [wpf_pkg::CFG_W-1:0]          cfg_data,
    output logic                               result_valid,
    output logic signed [wpf_pkg::OUT_W-1:0]   velocity_x,
    output logic signed [wpf_pkg::OUT_W-1:0]   velocity_y,
    output logic signed [wpf_pkg::OUT_W-1:0]   turn_rate,
    output logic [wpf_pkg::IDX_W-1:0]          target_index,
    output logic                               finished
);

    import wpf_pkg::*;

    typedef enum logic [4:0]
    {
        S_IDLE, S_SQ_L, S_SQ_H, S_SQ_F, S_CFG,
        S_RD, S_DIFF, S_MX, S_MY, S_SUM,
        S_FRD, S_FDIFF, S_FMX, S_FMY, S_FSUM, S_SEL,
        S_WRAP, S_TCHK, S_TMUL, S_TDIV, S_TWAIT,
        S_SQRT, S_SQWAIT,
        S_VXM, S_VXDIV, S_VXWAIT, S_VYM, S_VYDIV, S_VYWAIT, S_OUT
    } state_t;

    state_t state_reg;

    logic [DIST_W-1:0]  look_reg;
    logic [DIST_W-1:0]  haltd_reg;
    logic [DIST_W-1:0]  find_reg;
    logic [SPEED_W-1:0] minspd_reg;
    logic [ANGLE_W-1:0] dz_reg;
    logic [DIST_W-1:0]  mtr_reg;

    logic [LEN_W-1:0]   path_len_reg;
    logic [IDX_W-1:0]   cur_reg;
    logic               halt_latched_reg;
    logic               load_done_reg;

    logic [IDX_W-1:0]           scan_reg;
    logic [IDX_W-1:0]           first_reg;
    logic signed [COORD_W-1:0]  px_reg;
    logic signed [COORD_W-1:0]  py_reg;
    logic signed [ROBOT_W-1:0]  robot_reg;
    logic [D2_W-1:0]            prod_reg;
    logic [SQ_W-1:0]            l2_reg;
    logic [SQ_W-1:0]            h2_reg;
    logic [SQ_W-1:0]            f2_reg;
    logic [DIFF_W-1:0]          ax_reg;
    logic [DIFF_W-1:0]          ay_reg;
    logic                       sx_reg;
    logic                       sy_reg;
    logic [D2_W-1:0]            d2_reg;
    logic [SPEED_W-1:0]         speed_reg;
    logic signed [ERR_W-1:0]    err_reg;
    logic [ANGLE_W-1:0]         eff_reg;
    logic [SQRT_W-1:0]          len_reg;
    logic signed [OUT_W-1:0]    vx_reg;
    logic signed [OUT_W-1:0]    vy_reg;
    logic signed [OUT_W-1:0]    tr_reg;
    logic [IDX_W-1:0]           tgt_reg;
    logic                       fin_flag_reg;
    logic                       valid_reg;

    logic accept;
    logic last_scan;
    logic [LEN_W-1:0] load_base;
    logic             load_ok;

    way_t             wr_way;
    way_t             rd_way;
    logic [WAY_W-1:0] ram_rdata;
    logic             ram_wr;
    logic [IDX_W-1:0] ram_waddr;
    logic             ram_rd;
    logic [IDX_W-1:0] ram_raddr;

    logic [DIFF_W-1:0] mul_a;
    logic [DIFF_W-1:0] mul_b;

    arith_req_t        arith_req;
    logic [D2_W-1:0]   arith_arg;
    logic [DIVS_W-1:0] arith_dvs;
    logic              arith_busy;
    logic              arith_done;
    logic [D2_W-1:0]   arith_result;

    logic signed [DIFF_W-1:0] dx;
    logic signed [DIFF_W-1:0] dy;
    logic [D2_W-1:0]          d2_sum;
    logic [ANGLE_W-1:0]       ae;
    logic [OUT_W-1:0]         quo;

    assign accept    = start && (state_reg == S_IDLE);
    assign busy      = (state_reg != S_IDLE);
    assign last_scan = ({1'b0, scan_reg} == (path_len_reg - 1'b1));

    assign load_base = load_done_reg ? '0 : path_len_reg;
    assign load_ok   = (load_base < LEN_W'(MAX_POINTS));
    assign ram_wr    = accept && (command == CMD_LOAD) && load_ok;
    assign ram_waddr = load_base[IDX_W-1:0];

    always_comb
    begin
        wr_way.halt    = point_halt;
        wr_way.speed   = point_speed;
        wr_way.heading = point_heading;
        wr_way.y       = point_y;
        wr_way.x       = point_x;
    end

    assign ram_rd    = (state_reg == S_RD) || (state_reg == S_FRD);
    assign ram_raddr = (state_reg == S_RD) ? scan_reg : cur_reg;
    assign rd_way    = way_t'(ram_rdata);

    wpf_ram #(
        .WIDTH (WAY_W),
        .DEPTH (MAX_POINTS)
    ) u_store (
        .clk     (clk),
        .wr_en   (ram_wr),
        .wr_addr (ram_waddr),
        .wr_data (wr_way),
        .rd_en   (ram_rd),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    wpf_arith u_arith (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (arith_req),
        .arg     (arith_arg),
        .divisor (arith_dvs),
        .busy    (arith_busy),
        .done    (arith_done),
        .result  (arith_result)
    );

    assign dx     = {rd_way.x[COORD_W-1], rd_way.x} - {px_reg[COORD_W-1], px_reg};
    assign dy     = {rd_way.y[COORD_W-1], rd_way.y} - {py_reg[COORD_W-1], py_reg};
    assign d2_sum = d2_reg + prod_reg;
    assign ae     = err_reg[ERR_W-1] ? ANGLE_W'(-err_reg) : ANGLE_W'(err_reg);
    assign quo    = arith_result[OUT_W-1:0];

    // shared multiplier operands
    always_comb
    begin
        case (state_reg)
            S_SQ_L:
            begin
                mul_a = DIFF_W'(look_reg);
                mul_b = DIFF_W'(look_reg);
            end
            S_SQ_H:
            begin
                mul_a = DIFF_W'(haltd_reg);
                mul_b = DIFF_W'(haltd_reg);
            end
            S_SQ_F:
            begin
                mul_a = DIFF_W'(find_reg);
                mul_b = DIFF_W'(find_reg);
            end
            S_MX, S_FMX:
            begin
                mul_a = ax_reg;
                mul_b = ax_reg;
            end
            S_MY, S_FMY:
            begin
                mul_a = ay_reg;
                mul_b = ay_reg;
            end
            S_TMUL:
            begin
                mul_a = DIFF_W'(mtr_reg);
                mul_b = DIFF_W'(eff_reg);
            end
            S_VXM:
            begin
                mul_a = ax_reg;
                mul_b = DIFF_W'(speed_reg);
            end
            S_VYM:
            begin
                mul_a = ay_reg;
                mul_b = DIFF_W'(speed_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb
    begin
        arith_req.go = 1'b0;
        arith_req.op = OP_DIV;
        arith_arg    = '0;
        arith_dvs    = '0;
        case (state_reg)
            S_TDIV:
            begin
                arith_req.go = 1'b1;
                arith_arg    = {prod_reg[D2_W-2:0], 1'b0} + D2_W'(PI_Q12);
                arith_dvs    = DIVS_W'(TWO_PI_Q12);
            end
            S_SQRT:
            begin
                arith_req.go = 1'b1;
                arith_req.op = OP_SQRT;
                arith_arg    = d2_reg;
            end
            S_VXDIV, S_VYDIV:
            begin
                arith_req.go = 1'b1;
                arith_arg    = {prod_reg[D2_W-2:0], 1'b0} + D2_W'(len_reg);
                arith_dvs    = DIVS_W'({len_reg, 1'b0});
            end
            default:
            begin
                arith_req.go = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            look_reg         <= RST_LOOKAHEAD;
            haltd_reg        <= RST_HALT_DIST;
            find_reg         <= RST_FIN_DIST;
            minspd_reg       <= RST_MIN_SPEED;
            dz_reg           <= RST_DEAD_ZONE;
            mtr_reg          <= RST_MAX_TURN;
            path_len_reg     <= '0;
            cur_reg          <= '0;
            halt_latched_reg <= 1'b0;
            load_done_reg    <= 1'b0;
            valid_reg        <= 1'b0;
        end
        else
        begin
            valid_reg <= 1'b0;
            prod_reg  <= D2_W'(mul_a * mul_b);

            if (cfg_write)
            begin
                case (cfg_index)
                    REG_LOOKAHEAD: look_reg   <= cfg_data[DIST_W-1:0];
                    REG_HALT_DIST: haltd_reg  <= cfg_data[DIST_W-1:0];
                    REG_FIN_DIST:  find_reg   <= cfg_data[DIST_W-1:0];
                    REG_MIN_SPEED: minspd_reg <= cfg_data[SPEED_W-1:0];
                    REG_DEAD_ZONE: dz_reg     <= cfg_data;
                    REG_MAX_TURN:  mtr_reg    <= cfg_data[DIST_W-1:0];
                    default:       ;
                endcase
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        case (command)
                            CMD_LOAD:
                            begin
                                path_len_reg  <= load_ok ? load_base + 1'b1 : load_base;
                                load_done_reg <= point_last;
                            end
                            CMD_START:
                            begin
                                cur_reg          <= '0;
                                halt_latched_reg <= 1'b0;
                            end
                            CMD_TICK:
                            begin
                                if (path_len_reg == '0)
                                begin
                                    vx_reg       <= '0;
                                    vy_reg       <= '0;
                                    tr_reg       <= '0;
                                    tgt_reg      <= '0;
                                    fin_flag_reg <= 1'b0;
                                    valid_reg    <= 1'b1;
                                end
                                else
                                begin
                                    if ({1'b0, cur_reg} >= path_len_reg)
                                    begin
                                        cur_reg <= IDX_W'(path_len_reg - 1'b1);
                                    end
                                    px_reg    <= pose_x;
                                    py_reg    <= pose_y;
                                    robot_reg <= robot_heading;
                                    state_reg <= S_SQ_L;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                S_SQ_L: state_reg <= S_SQ_H;
                S_SQ_H:
                begin
                    l2_reg    <= prod_reg[SQ_W-1:0];
                    state_reg <= S_SQ_F;
                end
                S_SQ_F:
                begin
                    h2_reg    <= prod_reg[SQ_W-1:0];
                    state_reg <= S_CFG;
                end
                S_CFG:
                begin
                    f2_reg    <= prod_reg[SQ_W-1:0];
                    scan_reg  <= cur_reg;
                    first_reg <= cur_reg;
                    state_reg <= halt_latched_reg ? S_FRD : S_RD;
                end
                S_RD: state_reg <= S_DIFF;
                S_DIFF:
                begin
                    ax_reg <= dx[DIFF_W-1] ? DIFF_W'(-dx) : DIFF_W'(dx);
                    ay_reg <= dy[DIFF_W-1] ? DIFF_W'(-dy) : DIFF_W'(dy);
                    if (rd_way.halt && (scan_reg != first_reg))
                    begin
                        halt_latched_reg <= 1'b1;
                        cur_reg          <= scan_reg;
                        state_reg        <= S_FRD;
                    end
                    else
                    begin
                        state_reg <= S_MX;
                    end
                end
                S_MX: state_reg <= S_MY;
                S_MY:
                begin
                    d2_reg    <= prod_reg;
                    state_reg <= S_SUM;
                end
                S_SUM:
                begin
                    if ((d2_sum > D2_W'(l2_reg)) || last_scan)
                    begin
                        cur_reg   <= scan_reg;
                        state_reg <= S_FRD;
                    end
                    else
                    begin
                        scan_reg  <= scan_reg + 1'b1;
                        state_reg <= S_RD;
                    end
                end
                S_FRD: state_reg <= S_FDIFF;
                S_FDIFF:
                begin
                    ax_reg    <= dx[DIFF_W-1] ? DIFF_W'(-dx) : DIFF_W'(dx);
                    ay_reg    <= dy[DIFF_W-1] ? DIFF_W'(-dy) : DIFF_W'(dy);
                    sx_reg    <= dx[DIFF_W-1];
                    sy_reg    <= dy[DIFF_W-1];
                    speed_reg <= rd_way.speed;
                    err_reg   <= ERR_W'(rd_way.heading) - ERR_W'(robot_reg);
                    state_reg <= S_FMX;
                end
                S_FMX: state_reg <= S_FMY;
                S_FMY:
                begin
                    d2_reg    <= prod_reg;
                    state_reg <= S_FSUM;
                end
                S_FSUM:
                begin
                    d2_reg    <= d2_sum;
                    state_reg <= S_SEL;
                end
                S_SEL:
                begin
                    if (!halt_latched_reg && !(d2_reg < D2_W'(h2_reg)))
                    begin
                        speed_reg <= minspd_reg;
                    end
                    fin_flag_reg <= ({1'b0, cur_reg} == (path_len_reg - 1'b1))
                                    && (d2_reg < D2_W'(f2_reg));
                    tgt_reg      <= cur_reg;
                    state_reg    <= S_WRAP;
                end
                S_WRAP:
                begin
                    // bring the error into one turn, then into (-pi, pi]
                    if (err_reg < 0)
                    begin
                        err_reg <= err_reg + TWO_PI_Q12;
                    end
                    else if (err_reg >= TWO_PI_Q12)
                    begin
                        err_reg <= err_reg - TWO_PI_Q12;
                    end
                    else
                    begin
                        if (err_reg > PI_Q12)
                        begin
                            err_reg <= err_reg - TWO_PI_Q12;
                        end
                        state_reg <= S_TCHK;
                    end
                end
                S_TCHK:
                begin
                    if (ae > dz_reg)
                    begin
                        eff_reg   <= (ae < MIN_ERR) ? MIN_ERR : ae;
                        state_reg <= S_TMUL;
                    end
                    else
                    begin
                        tr_reg    <= '0;
                        state_reg <= S_SQRT;
                    end
                end
                S_TMUL: state_reg <= S_TDIV;
                S_TDIV: state_reg <= S_TWAIT;
                S_TWAIT:
                begin
                    if (arith_done)
                    begin
                        tr_reg    <= err_reg[ERR_W-1] ? -$signed(quo) : $signed(quo);
                        state_reg <= S_SQRT;
                    end
                end
                S_SQRT: state_reg <= S_SQWAIT;
                S_SQWAIT:
                begin
                    if (arith_done)
                    begin
                        len_reg <= arith_result[SQRT_W-1:0];
                        if (arith_result[SQRT_W-1:0] == '0)
                        begin
                            vx_reg    <= '0;
                            vy_reg    <= '0;
                            state_reg <= S_OUT;
                        end
                        else
                        begin
                            state_reg <= S_VXM;
                        end
                    end
                end
                S_VXM:   state_reg <= S_VXDIV;
                S_VXDIV: state_reg <= S_VXWAIT;
                S_VXWAIT:
                begin
                    if (arith_done)
                    begin
                        vx_reg    <= sx_reg ? -$signed(quo) : $signed(quo);
                        state_reg <= S_VYM;
                    end
                end
                S_VYM:   state_reg <= S_VYDIV;
                S_VYDIV: state_reg <= S_VYWAIT;
                S_VYWAIT:
                begin
                    if (arith_done)
                    begin
                        vy_reg    <= sy_reg ? -$signed(quo) : $signed(quo);
                        state_reg <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    valid_reg <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign result_valid = valid_reg;
    assign velocity_x   = vx_reg;
    assign velocity_y   = vy_reg;
    assign turn_rate    = tr_reg;
    assign target_index = tgt_reg;
    assign finished     = fin_flag_reg;

`ifndef SYNTHESIS
    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        path_len_reg <= LEN_W'(MAX_POINTS))
        else $error("path length beyond store depth");

    a_idx_in_path: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> ({1'b0, cur_reg} < path_len_reg))
        else $error("target index outside path during tick");

    a_arith_free: assert property (@(posedge clk) disable iff (!rst_n)
        arith_req.go |-> !arith_busy)
        else $error("arith unit started while busy");

    a_done_waits: assert property (@(posedge clk) disable iff (!rst_n)
        arith_done |-> (state_reg == S_TWAIT || state_reg == S_SQWAIT
                        || state_reg == S_VXWAIT || state_reg == S_VYWAIT))
        else $error("arith result with no waiting state");
`endif

endmodule

[test/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
    import wpf_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 2000;

    typedef struct packed
    {
        logic signed [OUT_W-1:0] vx;
        logic signed [OUT_W-1:0] vy;
        logic signed [OUT_W-1:0] tr;
        logic [IDX_W-1:0]        idx;
        logic                    fin;
    } steer_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic [CMD_W-1:0] command = '0;
    logic signed [COORD_W-1:0] point_x = '0, point_y = '0;
    logic signed [HEAD_W-1:0] point_heading = '0;
    logic [SPEED_W-1:0] point_speed = '0;
    logic point_halt = 1'b0, point_last = 1'b0;
    logic signed [COORD_W-1:0] pose_x = '0, pose_y = '0;
    logic signed [ROBOT_W-1:0] robot_heading = '0;
    logic cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0] cfg_data = '0;
    logic result_valid;
    logic signed [OUT_W-1:0] velocity_x, velocity_y, turn_rate;
    logic [IDX_W-1:0] target_index;
    logic finished;

    waypoint_path_follower dut (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // follower model state
    longint wx[MAX_POINTS], wy[MAX_POINTS], wh[MAX_POINTS], wsp[MAX_POINTS];
    bit whalt[MAX_POINTS];
    int path_len, cur_idx;
    bit halt_lat, load_done;
    longint look_d, halt_d, fin_d, min_spd, dead_z, max_tr;

    steer_t pending_steer[$];
    int mismatches = 0;
    int idle_cycles = 0;
    bit timed_out = 0;

    function automatic longint int_sqrt(longint x);
        longint r, b;
        r = 0;
        b = 64'sd1 << 60;
        while (b > x) b = b >> 2;
        while (b != 0)
        begin
            if (x >= r + b)
            begin
                x = x - r - b;
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic longint scaled(longint d, longint spd, longint len);
        longint a, q;
        a = d < 0 ? -d : d;
        q = (2 * a * spd + len) / (2 * len);
        return d < 0 ? -q : q;
    endfunction

    function automatic bit follow_step(input logic [CMD_W-1:0] cmd, input longint px_i,
        input longint py_i, input longint ph, input longint ps, input bit hl, input bit lst,
        input longint rx, input longint ry, input longint rh, output steer_t res);
        longint dx, dy, d2, spd, len, err, ae, eff, mag, vx, vy, tr;
        int i, st, n;
        res = '0;
        if (cmd == CMD_LOAD)
        begin
            if (load_done)
            begin
                path_len = 0;
                load_done = 0;
            end
            if (path_len < MAX_POINTS)
            begin
                wx[path_len] = px_i; wy[path_len] = py_i; wh[path_len] = ph;
                wsp[path_len] = ps; whalt[path_len] = hl;
                path_len++;
            end
            if (lst) load_done = 1;
            return 0;
        end
        if (cmd == CMD_START)
        begin
            cur_idx = 0;
            halt_lat = 0;
            return 0;
        end
        if (cmd != CMD_TICK) return 0;
        if (path_len == 0) return 1;
        if (cur_idx >= path_len) cur_idx = path_len - 1;
        if (!halt_lat)
        begin
            st = cur_idx;
            for (i = st; i < path_len; i++)
            begin
                dx = wx[i] - rx; dy = wy[i] - ry;
                d2 = dx * dx + dy * dy;
                if (whalt[i] && i != st)
                begin
                    halt_lat = 1; cur_idx = i; break;
                end
                if (d2 > look_d * look_d)
                begin
                    cur_idx = i; break;
                end
                if (i == path_len - 1) cur_idx = i;
            end
        end
        n = cur_idx;
        dx = wx[n] - rx; dy = wy[n] - ry;
        d2 = dx * dx + dy * dy;
        spd = wsp[n];
        if (!halt_lat && !(d2 < halt_d * halt_d)) spd = min_spd;
        len = int_sqrt(d2);
        vx = 0; vy = 0; tr = 0;
        if (len != 0)
        begin
            vx = scaled(dx, spd, len);
            vy = scaled(dy, spd, len);
        end
        err = (wh[n] - rh) % 25736;
        if (err < 0) err += 25736;
        if (err > 12868) err -= 25736;
        ae = err < 0 ? -err : err;
        if (ae > dead_z)
        begin
            eff = ae < 643 ? 643 : ae;
            mag = (2 * max_tr * eff + 12868) / (2 * 12868);
            tr = err < 0 ? -mag : mag;
        end
        res.vx = vx[OUT_W-1:0];
        res.vy = vy[OUT_W-1:0];
        res.tr = tr[OUT_W-1:0];
        res.idx = n[IDX_W-1:0];
        res.fin = (n == path_len - 1) && (d2 < fin_d * fin_d);
        return 1;
    endfunction

    // result checker
    always @(posedge clk)
    begin
        steer_t got, want;
        if (rst_n && result_valid)
        begin
            got = '{velocity_x, velocity_y, turn_rate, target_index, finished};
            if (pending_steer.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %p", got);
            end
            else
            begin
                want = pending_steer.pop_front();
                if (got !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10) $display("mismatch: expected %p got %p", want, got);
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if ((start && !busy) || result_valid || cfg_write || !rst_n) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("waypoint_path_follower verification failed");
            $finish;
        end
    end

    int burst_left = 0;

    task automatic send_item(input logic [CMD_W-1:0] cmd, input longint px_i,
        input longint py_i, input longint ph, input longint ps, input bit hl, input bit lst,
        input longint rx, input longint ry, input longint rh);
        steer_t r;
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
            if (gap != 0)
            begin
                start <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        command <= cmd;
        point_x <= COORD_W'(px_i); point_y <= COORD_W'(py_i);
        point_heading <= HEAD_W'(ph); point_speed <= SPEED_W'(ps);
        point_halt <= hl; point_last <= lst;
        pose_x <= COORD_W'(rx); pose_y <= COORD_W'(ry); robot_heading <= ROBOT_W'(rh);
        start <= 1'b1;
        @(posedge clk);
        while (busy) @(posedge clk);
        if (follow_step(cmd, px_i, py_i, ph, ps, hl, lst, rx, ry, rh, r))
            pending_steer.push_back(r);
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        while (pending_steer.size() != 0 || busy) @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input longint val);
        wait_drained();
        cfg_write <= 1'b1; cfg_index <= idx; cfg_data <= CFG_W'(val);
        @(posedge clk);
        cfg_write <= 1'b0;
        case (idx)
            REG_LOOKAHEAD: look_d = val;
            REG_HALT_DIST: halt_d = val;
            REG_FIN_DIST:  fin_d = val;
            REG_MIN_SPEED: min_spd = val;
            REG_DEAD_ZONE: dead_z = val;
            REG_MAX_TURN:  max_tr = val;
            default: ;
        endcase
    endtask

    function automatic longint rnd_coord();
        return longint'($urandom_range(0, 1048575)) - 524288;
    endfunction

    function automatic longint rnd_head();
        return longint'($urandom_range(0, 25736)) - 12868;
    endfunction

    function automatic longint rnd_robot();
        return longint'($urandom_range(0, 262143)) - 131072;
    endfunction

    task automatic tick(input longint rx, input longint ry, input longint rh);
        send_item(CMD_TICK, 0, 0, 0, 0, 0, 0, rx, ry, rh);
    endtask

    task automatic load(input longint x, input longint y, input longint h, input longint s,
        input bit hl, input bit lst);
        send_item(CMD_LOAD, x, y, h, s, hl, lst, rnd_coord(), rnd_coord(), rnd_robot());
    endtask

    task automatic test_directed();
        tick(0, 0, 0);                      // empty path
        send_item(2'd3, 1, 1, 1, 1, 1, 1, 1, 1, 1);   // unknown command
        load(524287, -524288, 12868, 8191, 0, 0);
        load(-524288, 524287, -12868, 0, 1, 0);
        load(100, 100, 0, 500, 0, 1);
        send_item(CMD_START, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        tick(524287, -524288, 131071);      // target on pose
        tick(0, 0, -131072);
        tick(-524288, 524287, 0);
        tick(100, 100, 0);
        tick(110, 90, 12868);
        load(0, 0, 0, 0, 0, 1);             // new one-point path, index stale
        tick(5, 5, 0);
        tick(0, 0, 643);
    endtask

    task automatic test_registers();
        write_reg(REG_LOOKAHEAD, 0);
        write_reg(REG_HALT_DIST, 8191);
        write_reg(REG_FIN_DIST, 8191);
        write_reg(REG_MIN_SPEED, 8191);
        write_reg(REG_DEAD_ZONE, 0);
        write_reg(REG_MAX_TURN, 8191);
        tick(3, -4, 200);
        tick(8000, 0, 5000);
        write_reg(REG_LOOKAHEAD, 8191);
        write_reg(REG_HALT_DIST, 0);
        write_reg(REG_FIN_DIST, 0);
        write_reg(REG_MIN_SPEED, 0);
        write_reg(REG_DEAD_ZONE, 12868);
        write_reg(REG_MAX_TURN, 0);
        tick(3, -4, 200);
    endtask

    task automatic random_path(input int npts, input int nticks, input longint span);
        longint bx, by;
        bx = rnd_coord() / 2; by = rnd_coord() / 2;
        for (int i = 0; i < npts; i++)
            load(bx + i * span / 2 + $urandom_range(0, 200), by + $urandom_range(0, 300),
                 rnd_head(), $urandom_range(0, 8191), $urandom_range(0, 5) == 0,
                 i == npts - 1);
        send_item(CMD_START, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        for (int t = 0; t < nticks; t++)
            tick(bx + t * span * npts / (2 * nticks) + $urandom_range(0, 100) - 50,
                 by + $urandom_range(0, 200) - 100, rnd_robot());
    endtask

    task automatic test_random();
        for (int p = 0; p < 22; p++)
        begin
            case (p % 5)
                0: begin write_reg(REG_LOOKAHEAD, 82); write_reg(REG_HALT_DIST, 51);
                   write_reg(REG_FIN_DIST, 51); write_reg(REG_MIN_SPEED, 384);
                   write_reg(REG_DEAD_ZONE, 357); write_reg(REG_MAX_TURN, 6434); end
                1: write_reg(REG_LOOKAHEAD, $urandom_range(0, 8191));
                2: write_reg(REG_DEAD_ZONE, $urandom_range(0, 12868));
                3: write_reg(REG_MAX_TURN, $urandom_range(0, 8191));
                default: write_reg(REG_MIN_SPEED, $urandom_range(0, 8191));
            endcase
            random_path($urandom_range(2, 10), $urandom_range(6, 14), $urandom_range(20, 400));
            if ($urandom_range(0, 2) == 0)
                send_item(CMD_W'($urandom_range(0, 3)), rnd_coord(), rnd_coord(), rnd_head(),
                          $urandom_range(0, 8191), $urandom_range(0, 1) == 1,
                          $urandom_range(0, 1) == 1,
                          rnd_coord(), rnd_coord(), rnd_robot());
        end
    endtask

    task automatic test_full_store();
        for (int i = 0; i < MAX_POINTS + 3; i++)
            load(i * 40, 0, 0, 300, 0, 0);
        send_item(CMD_START, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        write_reg(REG_LOOKAHEAD, 8191);
        tick(0, 0, 0);
        tick(5000, 0, 0);
        load(0, 0, 0, 0, 0, 1);
        load(1, 1, 0, 0, 0, 1);
        tick(0, 0, 0);
    endtask

    initial
    begin
        look_d = RST_LOOKAHEAD; halt_d = RST_HALT_DIST; fin_d = RST_FIN_DIST;
        min_spd = RST_MIN_SPEED; dead_z = RST_DEAD_ZONE; max_tr = RST_MAX_TURN;
        path_len = 0; cur_idx = 0; halt_lat = 0; load_done = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_registers();
        test_random();
        wait_drained();           // sender holds off until every result has come
        test_full_store();
        fork
            wait_drained();
            begin
                repeat (DRAIN_CYCLES * 200) @(posedge clk);
                timed_out = 1;
            end
        join_any
        disable fork;
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (timed_out || mismatches != 0 || pending_steer.size() != 0)
            $display("waypoint_path_follower verification failed");
        else
            $display("waypoint_path_follower verification clean");
        $finish;
    end
endmodule

[sim.f]
hw/rtl/wpf_pkg.sv
hw/rtl/wpf_ram.sv
hw/rtl/wpf_arith.sv
hw/rtl/waypoint_path_follower.sv
test/tb_top.sv
